// File: rtl/identical_triangle_singular_quad_map_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the identical-triangle quadrature mapper.
// Each macro expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef IDENTICAL_TRIANGLE_SINGULAR_QUAD_MAP_TOP_ASSERT_SVH
`define IDENTICAL_TRIANGLE_SINGULAR_QUAD_MAP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITSQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/itsq_pkg.sv
// ----------------------------------------------------------------------------
// itsq_pkg
// Widths, constants and saturating Q2.30 arithmetic for the quadrature mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package itsq_pkg;

  localparam int IN_W     = 31;
  localparam int Q_W      = 32;
  localparam int Q_FRAC   = 30;
  localparam int REGION_W = 3;
  localparam int NUM_REGIONS = 6;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [REGION_W-1:0]   region_t;

  localparam q_t Q_ONE = q_t'(1) <<< Q_FRAC;
  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam q_t Q_ZERO = '0;

  localparam region_t REGION_A    = 3'd0;
  localparam region_t REGION_LAST = 3'd5;

  // Saturate a value two bits wider than Q_W into the signed Q_W range.
  function automatic q_t sat_wide(input logic signed [Q_W+1:0] v);
    q_t res;
    if (v[Q_W+1:Q_W-1] == 3'b000 || v[Q_W+1:Q_W-1] == 3'b111) begin
      res = v[Q_W-1:0];
    end else if (v[Q_W+1]) begin
      res = Q_MIN;
    end else begin
      res = Q_MAX;
    end
    return res;
  endfunction

  function automatic q_t qadd(input q_t x, input q_t y);
    logic signed [Q_W+1:0] sum;
    sum = {{2{x[Q_W-1]}}, x} + {{2{y[Q_W-1]}}, y};
    return sat_wide(sum);
  endfunction

  function automatic q_t qsub(input q_t x, input q_t y);
    logic signed [Q_W+1:0] dif;
    dif = {{2{x[Q_W-1]}}, x} - {{2{y[Q_W-1]}}, y};
    return sat_wide(dif);
  endfunction

  function automatic q_t qneg(input q_t x);
    return qsub(Q_ZERO, x);
  endfunction

  // Full product shifted right by the fraction width, rounding toward minus
  // infinity, then saturated.
  function automatic q_t qmul(input q_t x, input q_t y);
    logic signed [2*Q_W-1:0] prod;
    prod = x * y;
    return sat_wide(prod[2*Q_W-1:Q_FRAC]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/itsq_if.sv
// ----------------------------------------------------------------------------
// itsq_in_if / itsq_out_if
// Valid/ready channels carrying one base point and one mapped point.
// ----------------------------------------------------------------------------
`default_nettype none

interface itsq_in_if;
  import itsq_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] coord_a;
  logic [IN_W-1:0] coord_b;
  logic [IN_W-1:0] coord_c;
  logic [IN_W-1:0] coord_d;
  logic [IN_W-1:0] weight_in;
  logic            final_point;

  modport source (
    output valid, coord_a, coord_b, coord_c, coord_d, weight_in, final_point,
    input  ready
  );
  modport sink (
    input  valid, coord_a, coord_b, coord_c, coord_d, weight_in, final_point,
    output ready
  );
endinterface

interface itsq_out_if;
  import itsq_pkg::*;

  logic            valid;
  logic            ready;
  region_t         region;
  q_t              out_x0;
  q_t              out_x1;
  q_t              out_x2;
  q_t              out_x3;
  q_t              out_x4;
  q_t              out_x5;
  logic [IN_W-1:0] weight_out;
  logic            run_last;
  logic            rule_done;

  modport source (
    output valid, region, out_x0, out_x1, out_x2, out_x3, out_x4, out_x5,
           weight_out, run_last, rule_done,
    input  ready
  );
  modport sink (
    input  valid, region, out_x0, out_x1, out_x2, out_x3, out_x4, out_x5,
           weight_out, run_last, rule_done,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/identical_triangle_singular_quad_map_top.sv
// ----------------------------------------------------------------------------
// identical_triangle_singular_quad_map_top
// Maps one 4-D base quadrature point to six 6-D points over two identical
// triangles, with a shared transformed weight, in saturating Q2.30.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Carries
//  in_chan   in   valid/ready    coord_a..coord_d, weight_in, final_point
//  out_chan  out  valid/ready    region, out_x0..out_x5, weight_out, flags
//
//  Each request produces six results, one per cycle unless out_chan stalls, so
//  the single result port, not the arithmetic, limits the request rate; later
//  requests are taken into the arithmetic stages while earlier results drain.
//  A taken request passes through four arithmetic stages, then the region
//  buffer and the output register.
//  Reset (rst_n low, synchronous) clears valid bits and the region counter.
//  Back-pressure on out_chan stalls each full stage in place; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "identical_triangle_singular_quad_map_top_assert.svh"

module identical_triangle_singular_quad_map_top (
  input  logic       clk,
  input  logic       rst_n,
  itsq_in_if.sink    in_chan,
  itsq_out_if.source out_chan
);
  import itsq_pkg::*;

  // Flow control.
  logic out_load, hold_take, hold_free;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // Stage 1: inputs and the two complements.
  logic s1_v_r, s1_fin_r;
  q_t   s1_a_r, s1_b_r, s1_c_r, s1_d_r, s1_w_r, s1_oma_r, s1_omb_r;
  q_t   in_a, in_b;

  // Stage 2: first products.
  logic s2_v_r, s2_fin_r;
  q_t   s2_a_r, s2_oma_r, s2_omb_r, s2_m1_r, s2_q_r, s2_r_r, s2_wa_r, s2_oo_r;

  // Stage 3: second products.
  logic s3_v_r, s3_fin_r;
  q_t   s3_a_r, s3_q_r, s3_r_r, s3_p_r, s3_oo_r, s3_wb_r;

  // Stage 4: weight and the derived coordinates.
  logic            s4_v_r, s4_fin_r;
  q_t              s4_a_r, s4_p_r, s4_q_r, s4_r_r, s4_s_r, s4_pr_r, s4_nr_r;
  logic [IN_W-1:0] s4_wt_r;
  q_t              wt_nxt;

  // Region buffer holding all six 4-vectors of one request.
  logic            hold_v_r, hold_fin_r;
  region_t         hold_cnt_r, hold_cnt_nxt;
  q_t              hold_vec_r [NUM_REGIONS][4];
  q_t              hold_vec_nxt [NUM_REGIONS][4];
  logic [IN_W-1:0] hold_wt_r;

  // Output register.
  logic            out_v_r, out_last_r, out_done_r;
  region_t         out_region_r;
  q_t              out_x0_r, out_x1_r, out_x2_r, out_x3_r, out_x4_r, out_x5_r;
  logic [IN_W-1:0] out_wt_r;

  assign out_load  = !out_v_r || out_chan.ready;
  assign hold_take = hold_v_r && out_load;
  assign hold_free = !hold_v_r || (hold_take && hold_cnt_r == REGION_LAST);
  assign s4_ready  = !s4_v_r || hold_free;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;

  assign in_chan.ready = s1_ready;

  assign in_a = {1'b0, in_chan.coord_a};
  assign in_b = {1'b0, in_chan.coord_b};

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_chan.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        s3_v_r <= s2_v_r;
      end
      if (s4_ready) begin
        s4_v_r <= s3_v_r;
      end
      if (hold_free) begin
        hold_v_r <= s4_v_r;
      end
      if (out_load) begin
        out_v_r <= hold_v_r;
      end
    end
  end

  always_comb begin
    if (hold_free) begin
      hold_cnt_nxt = REGION_A;
    end else if (hold_take) begin
      hold_cnt_nxt = hold_cnt_r + 3'd1;
    end else begin
      hold_cnt_nxt = hold_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r <= REGION_A;
    end else begin
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_a_r   <= in_a;
      s1_b_r   <= in_b;
      s1_c_r   <= {1'b0, in_chan.coord_c};
      s1_d_r   <= {1'b0, in_chan.coord_d};
      s1_w_r   <= {1'b0, in_chan.weight_in};
      s1_fin_r <= in_chan.final_point;
      s1_oma_r <= qsub(Q_ONE, in_a);
      s1_omb_r <= qsub(Q_ONE, in_b);
    end
    if (s2_ready) begin
      s2_a_r   <= s1_a_r;
      s2_oma_r <= s1_oma_r;
      s2_omb_r <= s1_omb_r;
      s2_fin_r <= s1_fin_r;
      s2_m1_r  <= qmul(s1_d_r, s1_omb_r);
      s2_q_r   <= qmul(s1_b_r, s1_oma_r);
      s2_r_r   <= qmul(s1_c_r, s1_a_r);
      s2_wa_r  <= qmul(s1_w_r, s1_a_r);
      s2_oo_r  <= qmul(s1_oma_r, s1_oma_r);
    end
    if (s3_ready) begin
      s3_a_r   <= s2_a_r;
      s3_q_r   <= s2_q_r;
      s3_r_r   <= s2_r_r;
      s3_oo_r  <= s2_oo_r;
      s3_fin_r <= s2_fin_r;
      s3_p_r   <= qmul(s2_m1_r, s2_oma_r);
      s3_wb_r  <= qmul(s2_wa_r, s2_omb_r);
    end
    if (s4_ready) begin
      s4_a_r   <= s3_a_r;
      s4_p_r   <= s3_p_r;
      s4_q_r   <= s3_q_r;
      s4_r_r   <= s3_r_r;
      s4_fin_r <= s3_fin_r;
      s4_s_r   <= qsub(s3_a_r, s3_r_r);
      s4_pr_r  <= qadd(s3_p_r, s3_r_r);
      s4_nr_r  <= qneg(s3_r_r);
      s4_wt_r  <= wt_nxt[IN_W-1:0];
    end
  end

  // A negative weight can only come from b above one and is clamped to zero.
  always_comb begin
    wt_nxt = qmul(s3_wb_r, s3_oo_r);
    if (wt_nxt[Q_W-1]) begin
      wt_nxt = Q_ZERO;
    end
  end

  // The three base regions and their mirrors.
  always_comb begin
    hold_vec_nxt[0][0] = s4_p_r;
    hold_vec_nxt[0][1] = s4_q_r;
    hold_vec_nxt[0][2] = s4_r_r;
    hold_vec_nxt[0][3] = s4_s_r;
    hold_vec_nxt[1][0] = s4_pr_r;
    hold_vec_nxt[1][1] = s4_q_r;
    hold_vec_nxt[1][2] = s4_nr_r;
    hold_vec_nxt[1][3] = s4_a_r;
    hold_vec_nxt[2][0] = s4_q_r;
    hold_vec_nxt[2][1] = s4_pr_r;
    hold_vec_nxt[2][2] = s4_a_r;
    hold_vec_nxt[2][3] = s4_nr_r;
    for (int k = 0; k < 3; k++) begin
      hold_vec_nxt[k+3][0] = qadd(hold_vec_nxt[k][0], hold_vec_nxt[k][2]);
      hold_vec_nxt[k+3][1] = qadd(hold_vec_nxt[k][1], hold_vec_nxt[k][3]);
      hold_vec_nxt[k+3][2] = qneg(hold_vec_nxt[k][2]);
      hold_vec_nxt[k+3][3] = qneg(hold_vec_nxt[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (hold_free) begin
      hold_vec_r <= hold_vec_nxt;
      hold_wt_r  <= s4_wt_r;
      hold_fin_r <= s4_fin_r;
    end
  end

  // Output register: one region per cycle from the buffer while out_chan is ready.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_region_r <= hold_cnt_r;
      out_x0_r     <= hold_vec_r[hold_cnt_r][0];
      out_x1_r     <= hold_vec_r[hold_cnt_r][1];
      out_x2_r     <= qadd(hold_vec_r[hold_cnt_r][0], hold_vec_r[hold_cnt_r][2]);
      out_x3_r     <= qadd(hold_vec_r[hold_cnt_r][1], hold_vec_r[hold_cnt_r][3]);
      out_x4_r     <= hold_vec_r[hold_cnt_r][2];
      out_x5_r     <= hold_vec_r[hold_cnt_r][3];
      out_wt_r     <= hold_wt_r;
      out_last_r   <= (hold_cnt_r == REGION_LAST);
      out_done_r   <= (hold_cnt_r == REGION_LAST) && hold_fin_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.region     = out_region_r;
  assign out_chan.out_x0     = out_x0_r;
  assign out_chan.out_x1     = out_x1_r;
  assign out_chan.out_x2     = out_x2_r;
  assign out_chan.out_x3     = out_x3_r;
  assign out_chan.out_x4     = out_x4_r;
  assign out_chan.out_x5     = out_x5_r;
  assign out_chan.weight_out = out_wt_r;
  assign out_chan.run_last   = out_last_r;
  assign out_chan.rule_done  = out_done_r;

  // Assertions.
  `ITSQ_ASSERT_SAME(a_hold_cnt_range, hold_v_r, hold_cnt_r <= REGION_LAST,
                    "region count out of range")
  `ITSQ_ASSERT_SAME(a_last_matches_region, out_v_r,
                    out_last_r == (out_region_r == REGION_LAST),
                    "run_last not on last region")
  `ITSQ_ASSERT_SAME(a_done_only_last, out_v_r && out_done_r, out_last_r,
                    "rule_done without run_last")
  `ITSQ_ASSERT_NEXT(a_region_sequence, out_v_r && out_chan.ready && !out_last_r,
                    out_v_r && out_region_r == $past(out_region_r) + 3'd1,
                    "regions not emitted in order")

endmodule

`default_nettype wire

// File: bench/identical_triangle_singular_quad_map_top_tb.sv
// ----------------------------------------------------------------------------
// identical_triangle_singular_quad_map_top_tb
// Self-checking bench for the identical-triangle quadrature mapper. Each base
// point request is pushed through a behavioral Q2.30 mapper, or taken from a
// precomputed table for typed rows, and its six mapped points are queued in
// region order. Every point the block hands back is checked field by field
// against the oldest queued one. A short table of corner requests runs first,
// followed by random requests with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module identical_triangle_singular_quad_map_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itsq_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_POINTS = 480;
  localparam int CALM_FIRST    = 180;
  localparam int CALM_LAST     = 300;
  localparam int IDLE_PCT      = 35;
  localparam int DRAIN_CYCLES  = 24;
  localparam int MAX_REPORTS   = 10;
  localparam int LIMIT_NS      = 3_000_000;
  localparam int NO_TYPED      = -1;

  localparam logic [IN_W-1:0] IN_ZERO = '0;
  localparam logic [IN_W-1:0] IN_LSB  = 31'h0000_0001;
  localparam logic [IN_W-1:0] IN_HALF = 31'h2000_0000;
  localparam logic [IN_W-1:0] IN_ONE  = 31'h4000_0000;
  localparam logic [IN_W-1:0] IN_MAX  = 31'h7FFF_FFFF;
  localparam logic [IN_W-1:0] IN_ALT0 = 31'h5555_5555;
  localparam logic [IN_W-1:0] IN_ALT1 = 31'h2AAA_AAAA;

  localparam q_t QP1 = 32'sh4000_0000;
  localparam q_t QM1 = 32'shC000_0000;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint FX_ONE = 64'sd1 <<< Q_FRAC;

  typedef q_t [3:0] vec4_t;
  typedef vec4_t [NUM_REGIONS-1:0] region_vecs_t;

  typedef struct packed {
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    logic [IN_W-1:0] c;
    logic [IN_W-1:0] d;
    logic [IN_W-1:0] w;
    logic            fin;
  } base_point_t;

  typedef struct packed {
    base_point_t pt;
    int          typed;
  } stim_row_t;

  typedef struct packed {
    region_t         region;
    q_t [5:0]        x;
    logic [IN_W-1:0] weight;
    logic            run_last;
    logic            rule_done;
  } mapped_point_t;

  logic clk = 1'b0;
  logic rst_n;

  itsq_in_if  in_chan ();
  itsq_out_if out_chan ();

  identical_triangle_singular_quad_map_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #CLK_HALF clk = ~clk;

  mapped_point_t pending_points [$];
  region_vecs_t  typed_vecs [3];
  stim_row_t     directed_rows [$];
  int            mismatches    = 0;
  int            src_idle_pct  = IDLE_PCT;
  int            sink_idle_pct = IDLE_PCT;

  // ---------------------------------------------------------------------------
  // Behavioral Q2.30 mapper
  // ---------------------------------------------------------------------------
  function automatic longint sat_q(input longint v);
    if (v > SAT_HI) begin
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      return SAT_LO;
    end
    return v;
  endfunction

  // Arithmetic shift drops the low bits, which floors toward minus infinity.
  function automatic longint mul_q(input longint x, input longint y);
    return sat_q((x * y) >>> Q_FRAC);
  endfunction

  function automatic q_t add_q(input q_t x, input q_t y);
    return q_t'(sat_q(longint'(x) + longint'(y)));
  endfunction

  function automatic vec4_t vec4(input q_t x0, input q_t x1, input q_t x2, input q_t x3);
    vec4_t v;
    v[0] = x0;
    v[1] = x1;
    v[2] = x2;
    v[3] = x3;
    return v;
  endfunction

  function automatic void map_base_point(input base_point_t pt, output region_vecs_t v,
                                         output logic [IN_W-1:0] w_out);
    longint a, b, c, d, w, oma, omb, p, q, r, s, pr, nr, wt;
    longint u [NUM_REGIONS][4];
    a   = longint'(pt.a);
    b   = longint'(pt.b);
    c   = longint'(pt.c);
    d   = longint'(pt.d);
    w   = longint'(pt.w);
    oma = sat_q(FX_ONE - a);
    omb = sat_q(FX_ONE - b);
    p   = mul_q(mul_q(d, omb), oma);
    q   = mul_q(b, oma);
    r   = mul_q(c, a);
    s   = sat_q(a - r);
    pr  = sat_q(p + r);
    nr  = sat_q(-r);
    wt  = mul_q(mul_q(mul_q(w, a), omb), mul_q(oma, oma));
    // A negative weight can only come from b above one; it is clamped to zero.
    if (wt < 0) begin
      wt = 0;
    end
    u[0] = '{p, q, r, s};
    u[1] = '{pr, q, nr, a};
    u[2] = '{q, pr, a, nr};
    for (int k = 0; k < 3; k++) begin
      u[k+3][0] = sat_q(u[k][0] + u[k][2]);
      u[k+3][1] = sat_q(u[k][1] + u[k][3]);
      u[k+3][2] = sat_q(-u[k][2]);
      u[k+3][3] = sat_q(-u[k][3]);
    end
    for (int k = 0; k < NUM_REGIONS; k++) begin
      v[k] = vec4(q_t'(u[k][0]), q_t'(u[k][1]), q_t'(u[k][2]), q_t'(u[k][3]));
    end
    w_out = wt[IN_W-1:0];
  endfunction

  // Expand each region's 4-vector into the six emitted coordinates.
  function automatic void queue_mapped_points(input region_vecs_t v, input logic [IN_W-1:0] w,
                                              input logic fin);
    mapped_point_t e;
    for (int k = 0; k < NUM_REGIONS; k++) begin
      e.region    = region_t'(k);
      e.x[0]      = v[k][0];
      e.x[1]      = v[k][1];
      e.x[2]      = add_q(v[k][0], v[k][2]);
      e.x[3]      = add_q(v[k][1], v[k][3]);
      e.x[4]      = v[k][2];
      e.x[5]      = v[k][3];
      e.weight    = w;
      e.run_last  = (k == NUM_REGIONS - 1);
      e.rule_done = (k == NUM_REGIONS - 1) && fin;
      pending_points.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t row(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                                    input logic [IN_W-1:0] c, input logic [IN_W-1:0] d,
                                    input logic [IN_W-1:0] w, input logic fin,
                                    input int typed);
    stim_row_t sr;
    sr.pt    = '{a: a, b: b, c: c, d: d, w: w, fin: fin};
    sr.typed = typed;
    return sr;
  endfunction

  // Mostly values inside the unit range, with corners and full-width noise.
  function automatic logic [IN_W-1:0] rand_coord();
    case ($urandom_range(19))
      0: return IN_ZERO;
      1: return IN_ONE;
      2: return IN_MAX;
      3: return IN_ONE - IN_W'($urandom_range(3)) + IN_W'($urandom_range(3));
      4, 5, 6: return IN_W'($urandom());
      default: return IN_W'($urandom_range(32'h4000_0000));
    endcase
  endfunction

  task automatic send_point(input base_point_t pt, input int typed);
    region_vecs_t    v;
    logic [IN_W-1:0] w;
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.coord_a     <= pt.a;
    in_chan.coord_b     <= pt.b;
    in_chan.coord_c     <= pt.c;
    in_chan.coord_d     <= pt.d;
    in_chan.weight_in   <= pt.w;
    in_chan.final_point <= pt.fin;
    do begin
      @(posedge clk);
    end while (in_chan.ready !== 1'b1);
    if (typed == NO_TYPED) begin
      map_base_point(pt, v, w);
    end else begin
      // Every typed row has a or 1-a at zero, so its weight is zero.
      v = typed_vecs[typed];
      w = '0;
    end
    queue_mapped_points(v, w, pt.fin);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    mapped_point_t got, want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.region    = out_chan.region;
      got.x[0]      = out_chan.out_x0;
      got.x[1]      = out_chan.out_x1;
      got.x[2]      = out_chan.out_x2;
      got.x[3]      = out_chan.out_x3;
      got.x[4]      = out_chan.out_x4;
      got.x[5]      = out_chan.out_x5;
      got.weight    = out_chan.weight_out;
      got.run_last  = out_chan.run_last;
      got.rule_done = out_chan.rule_done;
      if (pending_points.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: point with no request pending: region %0d", $realtime, got.region);
        end
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (got.region !== want.region || got.x !== want.x || got.weight !== want.weight ||
            got.run_last !== want.run_last || got.rule_done !== want.rule_done) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: mismatch, expected region %0d x %h %h %h %h %h %h w %h last %b done %b",
                     $realtime, want.region, want.x[0], want.x[1], want.x[2], want.x[3],
                     want.x[4], want.x[5], want.weight, want.run_last, want.rule_done);
            $display("%0t:           actual   region %0d x %h %h %h %h %h %h w %h last %b done %b",
                     $realtime, got.region, got.x[0], got.x[1], got.x[2], got.x[3],
                     got.x[4], got.x[5], got.weight, got.run_last, got.rule_done);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    base_point_t pt;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.coord_a     = '0;
    in_chan.coord_b     = '0;
    in_chan.coord_c     = '0;
    in_chan.coord_d     = '0;
    in_chan.weight_in   = '0;
    in_chan.final_point = 1'b0;

    // All zero in, all zero out.
    typed_vecs[0] = '0;
    // a at one, everything else zero except the weight.
    typed_vecs[1][0] = vec4('0, '0, '0, QP1);
    typed_vecs[1][1] = vec4('0, '0, '0, QP1);
    typed_vecs[1][2] = vec4('0, '0, QP1, '0);
    typed_vecs[1][3] = vec4('0, QP1, '0, QM1);
    typed_vecs[1][4] = vec4('0, QP1, '0, QM1);
    typed_vecs[1][5] = vec4(QP1, '0, QM1, '0);
    // a at zero and b at one: only q survives.
    typed_vecs[2][0] = vec4('0, QP1, '0, '0);
    typed_vecs[2][1] = vec4('0, QP1, '0, '0);
    typed_vecs[2][2] = vec4(QP1, '0, '0, '0);
    typed_vecs[2][3] = vec4('0, QP1, '0, '0);
    typed_vecs[2][4] = vec4('0, QP1, '0, '0);
    typed_vecs[2][5] = vec4(QP1, '0, '0, '0);

    //                           a        b        c        d        w        fin  typed
    directed_rows.push_back(row(IN_ZERO, IN_ZERO, IN_ZERO, IN_ZERO, IN_ZERO, 1'b0, 0));
    directed_rows.push_back(row(IN_ONE,  IN_ZERO, IN_ZERO, IN_ZERO, IN_ONE,  1'b0, 1));
    directed_rows.push_back(row(IN_ZERO, IN_ONE,  IN_MAX,  IN_MAX,  IN_MAX,  1'b1, 2));
    directed_rows.push_back(row(IN_HALF, IN_HALF, IN_HALF, IN_HALF, IN_ONE,  1'b0, NO_TYPED));
    directed_rows.push_back(row(IN_MAX,  IN_MAX,  IN_MAX,  IN_MAX,  IN_MAX,  1'b1, NO_TYPED));
    directed_rows.push_back(row(IN_ONE,  IN_ONE,  IN_ONE,  IN_ONE,  IN_ONE,  1'b0, NO_TYPED));
    // b above one drives the weight negative, which must read back as zero.
    directed_rows.push_back(row(IN_HALF, IN_MAX,  IN_HALF, IN_HALF, IN_ONE,  1'b0, NO_TYPED));
    // Large a and w push the weight into saturation.
    directed_rows.push_back(row(IN_MAX,  IN_ZERO, IN_ZERO, IN_ZERO, IN_MAX,  1'b0, NO_TYPED));
    directed_rows.push_back(row(IN_MAX,  IN_ZERO, IN_MAX,  IN_MAX,  IN_HALF, 1'b1, NO_TYPED));
    directed_rows.push_back(row(IN_LSB,  IN_LSB,  IN_MAX,  IN_LSB,  IN_LSB,  1'b0, NO_TYPED));
    directed_rows.push_back(row(IN_ONE - IN_LSB, IN_ONE - IN_LSB, IN_ONE - IN_LSB,
                                IN_ONE - IN_LSB, IN_ONE - IN_LSB, 1'b0, NO_TYPED));
    directed_rows.push_back(row(IN_ALT0, IN_ALT1, IN_ALT0, IN_ALT1, IN_ALT0, 1'b0, NO_TYPED));
    directed_rows.push_back(row(IN_ALT1, IN_ALT0, IN_ALT1, IN_ALT0, IN_ALT1, 1'b1, NO_TYPED));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].pt, directed_rows[i].typed);
    end

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // One long stretch runs with the source never idling and the sink always ready.
      if (n == CALM_FIRST) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (n == CALM_LAST) begin
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
      end
      pt.a   = rand_coord();
      pt.b   = rand_coord();
      pt.c   = rand_coord();
      pt.d   = rand_coord();
      pt.w   = rand_coord();
      pt.fin = ($urandom_range(7) == 0);
      send_point(pt, NO_TYPED);
    end
    in_chan.valid <= 1'b0;

    while (pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("identical_triangle_singular_quad_map_top_tb: clean");
    end else begin
      $display("identical_triangle_singular_quad_map_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("identical_triangle_singular_quad_map_top_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
